// ===== rtl/core/bcomp_pkg.sv =====
// Shared types and constants for the barometer compensation block.
`timescale 1ns / 1ps
package bcomp_pkg;

	localparam int TEMP_FRAC_BITS  = 8;
	localparam int PRESS_FRAC_BITS = 6;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int HIGH_W = 40;

	localparam logic [1:0] REG_LOW  = 2'd0;
	localparam logic [1:0] REG_MID  = 2'd1;
	localparam logic [1:0] REG_HIGH = 2'd2;

	localparam int LIMB_W  = 32;
	localparam int A_LIMBS = 5;
	localparam int B_LIMBS = 2;
	localparam int A_W     = A_LIMBS * LIMB_W;
	localparam int B_W     = B_LIMBS * LIMB_W;
	localparam int P_W     = A_W + B_W;
	localparam int PP_W    = 2 * (LIMB_W + 1);

	localparam int SUM_W  = 96;
	localparam int Q_FRAC = 65;

	typedef logic signed [A_W-1:0]   mul_a_t;
	typedef logic signed [B_W-1:0]   mul_b_t;
	typedef logic signed [P_W-1:0]   mul_p_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [7:0]  t3;
		logic signed [15:0] p1;
		logic signed [15:0] p2;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic        [15:0] p5;
		logic        [15:0] p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} coef_t;

endpackage

// ===== rtl/core/bcomp_cfg.sv =====
// Calibration register file with APB access and coefficient unpacking.
`timescale 1ns / 1ps
module bcomp_cfg import bcomp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_t             coef
);

	logic [DATA_W-1:0] cal_lo_q;
	logic [DATA_W-1:0] cal_mid_q;
	logic [HIGH_W-1:0] cal_hi_q;
	logic [1:0]        idx;
	logic [167:0]      cal;

	assign idx    = paddr[4:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_lo_q  <= '0;
			cal_mid_q <= '0;
			cal_hi_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_LOW:  cal_lo_q  <= pwdata;
				REG_MID:  cal_mid_q <= pwdata;
				REG_HIGH: cal_hi_q  <= pwdata[HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOW:  prdata = cal_lo_q;
			REG_MID:  prdata = cal_mid_q;
			REG_HIGH: prdata = {{(DATA_W-HIGH_W){1'b0}}, cal_hi_q};
			default:  prdata = '0;
		endcase
	end

	assign cal = {cal_hi_q, cal_mid_q, cal_lo_q};

	always_comb begin
		coef.t1  = cal[15:0];
		coef.t2  = $signed(cal[31:16]);
		coef.t3  = $signed(cal[39:32]);
		coef.p1  = $signed(cal[55:40]);
		coef.p2  = $signed(cal[71:56]);
		coef.p3  = $signed(cal[79:72]);
		coef.p4  = $signed(cal[87:80]);
		coef.p5  = cal[103:88];
		coef.p6  = cal[119:104];
		coef.p7  = $signed(cal[127:120]);
		coef.p8  = $signed(cal[135:128]);
		coef.p9  = $signed(cal[151:136]);
		coef.p10 = $signed(cal[159:152]);
		coef.p11 = $signed(cal[167:160]);
	end

endmodule

// ===== rtl/core/bcomp_mul.sv =====
// Three-stage signed multiplier built from 33x33 limb products.
`timescale 1ns / 1ps
module bcomp_mul import bcomp_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  mul_a_t a,
	input  mul_b_t b,
	output mul_p_t p
);

	logic signed [LIMB_W:0]  al [A_LIMBS];
	logic signed [LIMB_W:0]  bl [B_LIMBS];
	logic signed [PP_W-1:0]  pp_s1 [A_LIMBS][B_LIMBS];
	mul_p_t                  row_c [B_LIMBS];
	mul_p_t                  row_s2 [B_LIMBS];
	mul_p_t                  prod_c;
	mul_p_t                  prod_s3;

	always_comb begin
		for (int i = 0; i < A_LIMBS; i++) begin
			if (i == A_LIMBS - 1)
				al[i] = $signed({a[A_W-1], a[i*LIMB_W +: LIMB_W]});
			else
				al[i] = $signed({1'b0, a[i*LIMB_W +: LIMB_W]});
		end
		for (int j = 0; j < B_LIMBS; j++) begin
			if (j == B_LIMBS - 1)
				bl[j] = $signed({b[B_W-1], b[j*LIMB_W +: LIMB_W]});
			else
				bl[j] = $signed({1'b0, b[j*LIMB_W +: LIMB_W]});
		end
	end

	always_comb begin
		for (int j = 0; j < B_LIMBS; j++) begin
			row_c[j] = '0;
			for (int i = 0; i < A_LIMBS; i++)
				row_c[j] = row_c[j] + (mul_p_t'(pp_s1[i][j]) <<< (i * LIMB_W));
		end
		prod_c = '0;
		for (int j = 0; j < B_LIMBS; j++)
			prod_c = prod_c + (row_s2[j] <<< (j * LIMB_W));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < A_LIMBS; i++)
				for (int j = 0; j < B_LIMBS; j++)
					pp_s1[i][j] <= PP_W'(al[i]) * PP_W'(bl[j]);
			for (int j = 0; j < B_LIMBS; j++)
				row_s2[j] <= row_c[j];
			prod_s3 <= prod_c;
		end
	end

	assign p = prod_s3;

endmodule

// ===== rtl/core/bcomp_dp.sv =====
// Compensation pipeline: temperature quadratic, pressure polynomial, rounding.
`timescale 1ns / 1ps
module bcomp_dp import bcomp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  coef_t               coef,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [23:0]         raw_pressure,
	input  logic [23:0]         raw_temperature,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  temperature_out,
	output logic [23:0]         pressure_out,
	output logic                saturated
);

	localparam int TR_SH = 48 - TEMP_FRAC_BITS;
	localparam int PR_SH = Q_FRAC - PRESS_FRAC_BITS;
	localparam int L1 = 68;
	localparam int L2 = Q_FRAC - 54;
	localparam int L5 = Q_FRAC - 20;
	localparam int L9 = Q_FRAC - 48;
	localparam int R3 = 104 - Q_FRAC;
	localparam int R4 = 159 - Q_FRAC;
	localparam int R6 = 77 - Q_FRAC;
	localparam int R7 = 128 - Q_FRAC;
	localparam int R8 = 181 - Q_FRAC;
	localparam int R10 = 96 - Q_FRAC;
	localparam int R11 = 65 - Q_FRAC;

	typedef struct packed {
		logic signed [15:0] tq;
		logic               sat;
	} tres_t;

	logic        adv;
	logic [14:1] vld_s;

	logic [23:0]        rp_s1;
	logic signed [24:0] d_s1;
	logic signed [24:0] rp_e;
	logic signed [16:0] p1m, p2m, p6e;

	logic signed [40:0] m1_s2;
	logic signed [49:0] m2_s2;
	logic signed [41:0] a5_s2, a5_s3, a5_s4, a5_s5, a5_s6;
	logic signed [41:0] a6_s2, a6_s3;
	logic signed [32:0] a7_s2, a7_s3, a7_s4, a7_s5, a7_s6;
	logic signed [32:0] a8_s2, a8_s3, a8_s4, a8_s5, a8_s6;
	logic signed [32:0] rp11_s2, rp11_s3;
	logic signed [48:0] r2_s2, r2_s3;

	logic signed [59:0] ti_s3, t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic signed [64:0] r2p9_s3, r2p9_s4, r2p9_s5, r2p9_s6;
	logic signed [57:0] r2p10_s3;
	logic signed [76:0] t2r_s4, t2r_s5, t2r_s6;

	logic signed [60:0] ti_rnd, ti_sh;
	tres_t tres_c;
	tres_t tres_s4, tres_s5, tres_s6, tres_s7, tres_s8, tres_s9, tres_s10;
	tres_t tres_s11, tres_s12, tres_s13;

	mul_p_t tt_p, m6_p, m10_p, m11_p, m3_p, m7_p, m4a_p, m8a_p, m4_p, m8_p;

	sum_t pa_s7, pb_s7, pab_s8, pab_s9, pc_s10, pc_s11, pc_s12, sum_s13;
	sum_t rn;
	logic big;

	assign adv       = !vld_s[14] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[13:1], in_valid};
	end

	assign rp_e = $signed({1'b0, rp_s1});
	assign p1m  = 17'(coef.p1) - 17'sd16384;
	assign p2m  = 17'(coef.p2) - 17'sd16384;
	assign p6e  = $signed({1'b0, coef.p6});

	assign ti_rnd = 61'(ti_s3) + (61'sd1 <<< (47 - TEMP_FRAC_BITS));
	assign ti_sh  = ti_rnd >>> TR_SH;

	always_comb begin
		if (ti_sh > 61'sd32767) begin
			tres_c.tq  = 16'sh7FFF;
			tres_c.sat = 1'b1;
		end else if (ti_sh < -61'sd32768) begin
			tres_c.tq  = -16'sh8000;
			tres_c.sat = 1'b1;
		end else begin
			tres_c.tq  = ti_sh[15:0];
			tres_c.sat = 1'b0;
		end
	end

	bcomp_mul u_mul_tt  (.clk, .en(adv), .a(mul_a_t'(ti_s3)),    .b(mul_b_t'(ti_s3)), .p(tt_p));
	bcomp_mul u_mul_6   (.clk, .en(adv), .a(mul_a_t'(a6_s3)),    .b(mul_b_t'(ti_s3)), .p(m6_p));
	bcomp_mul u_mul_10  (.clk, .en(adv), .a(mul_a_t'(r2p10_s3)), .b(mul_b_t'(ti_s3)), .p(m10_p));
	bcomp_mul u_mul_11  (.clk, .en(adv), .a(mul_a_t'(r2_s3)),    .b(mul_b_t'(rp11_s3)), .p(m11_p));
	bcomp_mul u_mul_3   (.clk, .en(adv), .a(mul_a_t'(tt_p)),  .b(mul_b_t'(coef.p7)), .p(m3_p));
	bcomp_mul u_mul_7   (.clk, .en(adv), .a(mul_a_t'(tt_p)),  .b(mul_b_t'(a7_s6)),   .p(m7_p));
	bcomp_mul u_mul_4a  (.clk, .en(adv), .a(mul_a_t'(tt_p)),  .b(mul_b_t'(coef.p8)), .p(m4a_p));
	bcomp_mul u_mul_8a  (.clk, .en(adv), .a(mul_a_t'(tt_p)),  .b(mul_b_t'(a8_s6)),   .p(m8a_p));
	bcomp_mul u_mul_4   (.clk, .en(adv), .a(mul_a_t'(m4a_p)), .b(mul_b_t'(t_s9)),    .p(m4_p));
	bcomp_mul u_mul_8   (.clk, .en(adv), .a(mul_a_t'(m8a_p)), .b(mul_b_t'(t_s9)),    .p(m8_p));

	assign rn  = sum_s13 >>> PR_SH;
	assign big = |rn[SUM_W-1:24];

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: capture, temperature offset
			rp_s1 <= raw_pressure;
			d_s1  <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.t1, 8'h00});
			// s2: first products
			m1_s2   <= 41'(d_s1) * 41'(coef.t2);
			m2_s2   <= 50'(d_s1) * 50'(d_s1);
			a5_s2   <= 42'(rp_e) * 42'(p1m);
			a6_s2   <= 42'(rp_e) * 42'(p2m);
			a7_s2   <= 33'(rp_e) * 33'(coef.p3);
			a8_s2   <= 33'(rp_e) * 33'(coef.p4);
			rp11_s2 <= 33'(rp_e) * 33'(coef.p11);
			r2_s2   <= 49'(rp_e) * 49'(rp_e);
			// s3: linearized temperature
			ti_s3    <= (60'(m1_s2) <<< 18) + 60'(m2_s2) * 60'(coef.t3);
			r2p9_s3  <= 65'(r2_s2) * 65'(coef.p9);
			r2p10_s3 <= 58'(r2_s2) * 58'(coef.p10);
			a5_s3    <= a5_s2;
			a6_s3    <= a6_s2;
			a7_s3    <= a7_s2;
			a8_s3    <= a8_s2;
			rp11_s3  <= rp11_s2;
			r2_s3    <= r2_s2;
			// s4..s6
			t2r_s4  <= 77'(ti_s3) * 77'(p6e);
			tres_s4 <= tres_c;
			t_s4    <= ti_s3;
			t_s5    <= t_s4;
			t_s6    <= t_s5;
			t_s7    <= t_s6;
			t_s8    <= t_s7;
			t_s9    <= t_s8;
			t2r_s5  <= t2r_s4;
			t2r_s6  <= t2r_s5;
			a5_s4   <= a5_s3;
			a5_s5   <= a5_s4;
			a5_s6   <= a5_s5;
			a7_s4   <= a7_s3;
			a7_s5   <= a7_s4;
			a7_s6   <= a7_s5;
			a8_s4   <= a8_s3;
			a8_s5   <= a8_s4;
			a8_s6   <= a8_s5;
			r2p9_s4 <= r2p9_s3;
			r2p9_s5 <= r2p9_s4;
			r2p9_s6 <= r2p9_s5;
			// s7..s13: Q65 term accumulation
			pa_s7 <= (sum_t'($signed({1'b0, coef.p5})) <<< L1)
				+ (sum_t'(t2r_s6) <<< L2)
				+ (sum_t'(a5_s6) <<< L5)
				+ sum_t'(m6_p >>> R6);
			pb_s7 <= (sum_t'(r2p9_s6) <<< L9)
				+ sum_t'(m10_p >>> R10)
				+ sum_t'(m11_p >>> R11);
			pab_s8  <= pa_s7 + pb_s7;
			pab_s9  <= pab_s8;
			pc_s10  <= pab_s9 + sum_t'(m3_p >>> R3) + sum_t'(m7_p >>> R7);
			pc_s11  <= pc_s10;
			pc_s12  <= pc_s11;
			sum_s13 <= pc_s12 + sum_t'(m4_p >>> R4) + sum_t'(m8_p >>> R8)
				+ (sum_t'(1) <<< (64 - PRESS_FRAC_BITS));
			tres_s5  <= tres_s4;
			tres_s6  <= tres_s5;
			tres_s7  <= tres_s6;
			tres_s8  <= tres_s7;
			tres_s9  <= tres_s8;
			tres_s10 <= tres_s9;
			tres_s11 <= tres_s10;
			tres_s12 <= tres_s11;
			tres_s13 <= tres_s12;
			// s14: output register
			temperature_out <= tres_s13.tq;
			if (rn[SUM_W-1]) begin
				pressure_out <= '0;
				saturated    <= 1'b1;
			end else if (big) begin
				pressure_out <= 24'hFFFFFF;
				saturated    <= 1'b1;
			end else begin
				pressure_out <= rn[23:0];
				saturated    <= tres_s13.sat;
			end
		end
	end

endmodule

// ===== rtl/core/barometer_compensation.sv =====
// Top level of the barometer compensation block.
`timescale 1ns / 1ps
// Takes one raw pressure/temperature transaction per clock and returns compensated
// temperature (1/256 degC), pressure (1/64 Pa) and a saturation flag from a 14-stage
// pipeline. Throughput is one transaction per cycle; the whole pipeline holds while
// a finished result waits on out_ready. Depth is set by the chain T, T^2, then
// T^3-order terms, each through a three-stage multiplier of 33x33 limb products.
// Calibration words must be written over APB (64-bit data, 8-byte stride) only while
// no transaction is in flight; the block itself does not enforce this.
module barometer_compensation import bcomp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        raw_pressure,
	input  logic [23:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temperature_out,
	output logic [23:0]        pressure_out,
	output logic               saturated
);

	coef_t coef;

	bcomp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .coef
	);

	bcomp_dp u_dp (
		.clk, .arst_n, .coef, .in_valid, .in_ready, .raw_pressure, .raw_temperature,
		.out_valid, .out_ready, .temperature_out, .pressure_out, .saturated
	);

endmodule

// ===== rtl/core/bcomp_checker.sv =====
// Port-level checks for the barometer compensation block.
`timescale 1ns / 1ps
module bcomp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] temperature_out,
	input logic [23:0]        pressure_out,
	input logic               saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_out)
			&& $stable(temperature_out) && $stable(saturated))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

	a_idle_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !$past(out_valid) |-> $past(in_ready))
		else $error("new result appeared while pipeline was held");

endmodule

bind barometer_compensation bcomp_checker u_bcomp_checker (.*);
